[sv/tun_pkg.sv]
`default_nettype none

package tun_pkg;

    // Default widths of the coordinate inputs and of the fraction of the result
    localparam int COORD_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF   = 14;

    // Vector lanes: x, y and z travel side by side through every stage
    localparam int LANES  = 3;
    localparam int LANE_X = 0;
    localparam int LANE_Y = 1;
    localparam int LANE_Z = 2;

endpackage

`default_nettype wire

[sv/tun_cross.sv]
`default_nettype none

// Edge vectors, partial products and cross product, three register stages.
module tun_cross import tun_pkg::*; #(
    parameter int CW = COORD_WIDTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [9*CW-1:0]             i_coords,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [LANES*(2*CW+1)-1:0]        o_mag,
    output logic [LANES-1:0]                 o_neg
);
    localparam int UW = CW + 1;
    localparam int PW = 2 * CW + 2;
    localparam int MW = 2 * CW + 1;

    logic r_v1, r_v2, r_v3;
    logic e1, e2, e3;

    logic signed [CW-1:0] pa [LANES];
    logic signed [CW-1:0] pb [LANES];
    logic signed [CW-1:0] pc [LANES];
    logic signed [UW-1:0] r_u [LANES];
    logic signed [UW-1:0] r_w [LANES];
    logic signed [PW-1:0] r_p [6];
    logic signed [PW-1:0] n_n [LANES];
    logic [MW-1:0]        r_mag [LANES];
    logic [LANES-1:0]     r_neg;

    assign e3      = !r_v3 || i_ready;
    assign e2      = !r_v2 || e3;
    assign e1      = !r_v1 || e2;
    assign o_ready = e1;
    assign o_valid = r_v3;

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            pa[k] = $signed(i_coords[k*CW +: CW]);
            pb[k] = $signed(i_coords[(k+3)*CW +: CW]);
            pc[k] = $signed(i_coords[(k+6)*CW +: CW]);
        end
        n_n[LANE_X] = r_p[0] - r_p[1];
        n_n[LANE_Y] = r_p[2] - r_p[3];
        n_n[LANE_Z] = r_p[4] - r_p[5];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (e1) r_v1 <= i_valid;
            if (e2) r_v2 <= r_v1;
            if (e3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e1) begin
            for (int k = 0; k < LANES; k++) begin
                r_u[k] <= UW'(pb[k]) - UW'(pa[k]);
                r_w[k] <= UW'(pc[k]) - UW'(pb[k]);
            end
        end
        if (e2) begin
            r_p[0] <= PW'(r_u[LANE_Y]) * PW'(r_w[LANE_Z]);
            r_p[1] <= PW'(r_u[LANE_Z]) * PW'(r_w[LANE_Y]);
            r_p[2] <= PW'(r_u[LANE_Z]) * PW'(r_w[LANE_X]);
            r_p[3] <= PW'(r_u[LANE_X]) * PW'(r_w[LANE_Z]);
            r_p[4] <= PW'(r_u[LANE_X]) * PW'(r_w[LANE_Y]);
            r_p[5] <= PW'(r_u[LANE_Y]) * PW'(r_w[LANE_X]);
        end
        if (e3) begin
            for (int k = 0; k < LANES; k++) begin
                r_neg[k] <= n_n[k][PW-1];
                r_mag[k] <= n_n[k][PW-1] ? MW'(-n_n[k]) : MW'(n_n[k]);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < LANES; k++) o_mag[k*MW +: MW] = r_mag[k];
    end
    assign o_neg = r_neg;

endmodule

`default_nettype wire

[sv/tun_norm.sv]
`default_nettype none

// Squares of the normal components, their sum, and the start values of the
// rounding search, three register stages.
module tun_norm import tun_pkg::*; #(
    parameter int CW = COORD_WIDTH_DEF,
    parameter int FB = FRAC_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic [LANES*(2*CW+1)-1:0]           i_mag,
    input  wire logic [LANES-1:0]                    i_neg,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic [LANES*(4*CW+2*FB+10)-1:0]          o_d0,
    output logic [4*CW+7+FB-1:0]                     o_y0,
    output logic [4*CW+4-1:0]                        o_s,
    output logic [LANES-1:0]                         o_neg,
    output logic                                     o_deg
);
    localparam int MW = 2 * CW + 1;
    localparam int H  = (MW + 1) / 2;
    localparam int HW = MW - H;
    localparam int SW = 2 * MW + 2;
    localparam int DW = 2 * MW + 2 * FB + 8;
    localparam int YW = SW + FB + 3;

    logic r_v1, r_v2, r_v3;
    logic e1, e2, e3;

    logic [H-1:0]      cl [LANES];
    logic [HW-1:0]     ch [LANES];
    logic [2*H-1:0]    r_ll [LANES];
    logic [MW-1:0]     r_lh [LANES];
    logic [2*HW-1:0]   r_hh [LANES];
    logic [2*MW-1:0]   r_sq [LANES];
    logic [LANES-1:0]  r_neg1, r_neg2, r_neg3;
    logic [SW-1:0]     n_sum;
    logic [SW-1:0]     r_s;
    logic [DW-1:0]     r_d0 [LANES];
    logic [YW-1:0]     r_y0;
    logic              r_deg;

    assign e3      = !r_v3 || i_ready;
    assign e2      = !r_v2 || e3;
    assign e1      = !r_v1 || e2;
    assign o_ready = e1;
    assign o_valid = r_v3;

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            cl[k] = i_mag[k*MW +: H];
            ch[k] = i_mag[k*MW+H +: HW];
        end
        n_sum = SW'(r_sq[LANE_X]) + SW'(r_sq[LANE_Y]) + SW'(r_sq[LANE_Z]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (e1) r_v1 <= i_valid;
            if (e2) r_v2 <= r_v1;
            if (e3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e1) begin
            for (int k = 0; k < LANES; k++) begin
                r_ll[k] <= (2*H)'(cl[k]) * (2*H)'(cl[k]);
                r_lh[k] <= MW'(cl[k]) * MW'(ch[k]);
                r_hh[k] <= (2*HW)'(ch[k]) * (2*HW)'(ch[k]);
            end
            r_neg1 <= i_neg;
        end
        if (e2) begin
            for (int k = 0; k < LANES; k++) begin
                r_sq[k] <= ((2*MW)'(r_hh[k]) << (2*H)) + ((2*MW)'(r_lh[k]) << (H+1))
                         + (2*MW)'(r_ll[k]);
            end
            r_neg2 <= r_neg1;
        end
        if (e3) begin
            for (int k = 0; k < LANES; k++) begin
                r_d0[k] <= (DW'(r_sq[k]) << (2*FB+2)) - DW'(n_sum);
            end
            r_y0   <= YW'(0) - YW'(n_sum);
            r_s    <= n_sum;
            r_deg  <= (n_sum == '0);
            r_neg3 <= r_neg2;
        end
    end

    always_comb begin
        for (int k = 0; k < LANES; k++) o_d0[k*DW +: DW] = r_d0[k];
    end
    assign o_y0  = r_y0;
    assign o_s   = r_s;
    assign o_neg = r_neg3;
    assign o_deg = r_deg;

endmodule

`default_nettype wire

[sv/tun_search.sv]
`default_nettype none

// Rounded quotient, one bit per stage from the top bit down. Each stage tries
// to set its bit: keep the slack R - (2q-1)^2*S and the product S*(2q-1), so
// the trial needs only shifted copies and one three-input subtract.
module tun_search import tun_pkg::*; #(
    parameter int CW = COORD_WIDTH_DEF,
    parameter int FB = FRAC_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic [LANES*(4*CW+2*FB+10)-1:0]     i_d0,
    input  wire logic [4*CW+7+FB-1:0]                i_y0,
    input  wire logic [4*CW+4-1:0]                   i_s,
    input  wire logic [LANES-1:0]                    i_neg,
    input  wire logic                                i_deg,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic [LANES*(FB+1)-1:0]                  o_q,
    output logic [LANES-1:0]                         o_neg,
    output logic                                     o_deg
);
    localparam int MW = 2 * CW + 1;
    localparam int SW = 2 * MW + 2;
    localparam int DW = 2 * MW + 2 * FB + 8;
    localparam int YW = SW + FB + 3;
    localparam int QW = FB + 1;
    localparam int NS = FB + 1;

    logic [NS:0]               rdy;
    logic [NS-1:0]             r_v;
    logic signed [DW-1:0]      r_d [NS-1][LANES];
    logic signed [YW-1:0]      r_y [NS-1][LANES];
    logic [SW-1:0]             r_s [NS-1];
    logic [QW-1:0]             r_q [NS][LANES];
    logic [LANES-1:0]          r_neg [NS];
    logic                      r_deg [NS];

    assign rdy[NS]  = i_ready;
    assign o_ready  = rdy[0];
    assign o_valid  = r_v[NS-1];
    assign o_neg    = r_neg[NS-1];
    assign o_deg    = r_deg[NS-1];

    always_comb begin
        for (int k = 0; k < LANES; k++) o_q[k*QW +: QW] = r_q[NS-1][k];
    end

    for (genvar gi = 0; gi < NS; gi++) begin : g_stage
        localparam int K = FB - gi;

        logic signed [DW-1:0] src_d [LANES];
        logic signed [YW-1:0] src_y [LANES];
        logic [QW-1:0]        src_q [LANES];
        logic [SW-1:0]        src_s;
        logic [LANES-1:0]     src_neg;
        logic                 src_deg;
        logic                 src_v;
        logic signed [DW-1:0] trial [LANES];
        logic                 take [LANES];
        logic [QW-1:0]        n_q [LANES];

        assign rdy[gi] = !r_v[gi] || rdy[gi+1];

        if (gi == 0) begin : g_head
            always_comb begin
                for (int k = 0; k < LANES; k++) begin
                    src_d[k] = $signed(i_d0[k*DW +: DW]);
                    src_y[k] = $signed(i_y0);
                    src_q[k] = '0;
                end
                src_s   = i_s;
                src_neg = i_neg;
                src_deg = i_deg;
                src_v   = i_valid;
            end
        end else begin : g_body
            always_comb begin
                for (int k = 0; k < LANES; k++) begin
                    src_d[k] = r_d[gi-1][k];
                    src_y[k] = r_y[gi-1][k];
                    src_q[k] = r_q[gi-1][k];
                end
                src_s   = r_s[gi-1];
                src_neg = r_neg[gi-1];
                src_deg = r_deg[gi-1];
                src_v   = r_v[gi-1];
            end
        end

        always_comb begin
            for (int k = 0; k < LANES; k++) begin
                trial[k] = src_d[k] - (DW'(src_y[k]) <<< (K+2)) - (DW'(src_s) << (2*K+2));
                take[k]  = !trial[k][DW-1];
                n_q[k]    = src_q[k];
                n_q[k][K] = take[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[gi] <= 1'b0;
            end else if (rdy[gi]) begin
                r_v[gi] <= src_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (rdy[gi]) begin
                for (int k = 0; k < LANES; k++) r_q[gi][k] <= n_q[k];
                r_neg[gi] <= src_neg;
                r_deg[gi] <= src_deg;
            end
        end

        if (gi < NS - 1) begin : g_carry
            logic signed [DW-1:0] n_d [LANES];
            logic signed [YW-1:0] n_y [LANES];

            always_comb begin
                for (int k = 0; k < LANES; k++) begin
                    n_d[k] = take[k] ? trial[k] : src_d[k];
                    n_y[k] = take[k] ? src_y[k] + $signed(YW'(src_s) << (K+1)) : src_y[k];
                end
            end

            always_ff @(posedge i_clk) begin
                if (rdy[gi]) begin
                    for (int k = 0; k < LANES; k++) begin
                        r_d[gi][k] <= n_d[k];
                        r_y[gi][k] <= n_y[k];
                    end
                    r_s[gi] <= src_s;
                end
            end
        end
    end

endmodule

`default_nettype wire

[sv/triangle_unit_normal.sv]
// Pipeline: three stages of cross product, three of squares and sum, FRAC_BITS + 1
//   of rounding search, one output register.
// Throughput: one triangle per cycle while the output is not stalled; every search
//   stage settles one result bit.
// Reset: synchronous, active low; clears every valid bit, payload is not reset.
`default_nettype none

module triangle_unit_normal import tun_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire logic                                      i_s_axis_tvalid,
    output logic                                           o_s_axis_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z,
    // third_x, third_y, third_z (lowest first), zero padded to bytes
    input  wire logic [((9*COORD_WIDTH+7)/8)*8-1:0]        i_s_axis_tdata,
    output logic                                           o_m_axis_tvalid,
    input  wire logic                                      i_m_axis_tready,
    // unit_x, unit_y, unit_z (lowest first), zero padded to bytes
    output logic [((3*(FRAC_BITS+2)+7)/8)*8-1:0]           o_m_axis_tdata,
    // degenerate
    output logic [0:0]                                     o_m_axis_tuser
);
    localparam int MW  = 2 * COORD_WIDTH + 1;
    localparam int SW  = 2 * MW + 2;
    localparam int DW  = 2 * MW + 2 * FRAC_BITS + 8;
    localparam int YW  = SW + FRAC_BITS + 3;
    localparam int QW  = FRAC_BITS + 1;
    localparam int OW  = FRAC_BITS + 2;
    localparam int OTW = ((3 * OW + 7) / 8) * 8;

    // cross product -> norm
    logic                   cr_valid, nm_ready;
    logic [LANES*MW-1:0]    cr_mag;
    logic [LANES-1:0]       cr_neg;

    // norm -> search
    logic                   nm_valid, sr_ready;
    logic [LANES*DW-1:0]    nm_d0;
    logic [YW-1:0]          nm_y0;
    logic [SW-1:0]          nm_s;
    logic [LANES-1:0]       nm_neg;
    logic                   nm_deg;

    // search -> output register
    logic                   sr_valid, out_en;
    logic [LANES*QW-1:0]    sr_q;
    logic [LANES-1:0]       sr_neg;
    logic                   sr_deg;

    logic                   r_out_valid;
    logic signed [OW-1:0]   r_unit [LANES];
    logic signed [OW-1:0]   n_unit [LANES];
    logic                   r_deg;

    tun_cross #(
        .CW (COORD_WIDTH)
    ) u_cross (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_coords (i_s_axis_tdata[9*COORD_WIDTH-1:0]),
        .o_valid  (cr_valid),
        .i_ready  (nm_ready),
        .o_mag    (cr_mag),
        .o_neg    (cr_neg)
    );

    tun_norm #(
        .CW (COORD_WIDTH),
        .FB (FRAC_BITS)
    ) u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cr_valid),
        .o_ready (nm_ready),
        .i_mag   (cr_mag),
        .i_neg   (cr_neg),
        .o_valid (nm_valid),
        .i_ready (sr_ready),
        .o_d0    (nm_d0),
        .o_y0    (nm_y0),
        .o_s     (nm_s),
        .o_neg   (nm_neg),
        .o_deg   (nm_deg)
    );

    tun_search #(
        .CW (COORD_WIDTH),
        .FB (FRAC_BITS)
    ) u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (nm_valid),
        .o_ready (sr_ready),
        .i_d0    (nm_d0),
        .i_y0    (nm_y0),
        .i_s     (nm_s),
        .i_neg   (nm_neg),
        .i_deg   (nm_deg),
        .o_valid (sr_valid),
        .i_ready (out_en),
        .o_q     (sr_q),
        .o_neg   (sr_neg),
        .o_deg   (sr_deg)
    );

    // Advance the output register when it is empty or its word is taken.
    assign out_en = !r_out_valid || i_m_axis_tready;

    // Apply the sign; drop the search result for a zero normal.
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            if (sr_deg) begin
                n_unit[k] = '0;
            end else if (sr_neg[k]) begin
                n_unit[k] = $signed(OW'(0) - OW'(sr_q[k*QW +: QW]));
            end else begin
                n_unit[k] = $signed(OW'(sr_q[k*QW +: QW]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_en) begin
            r_out_valid <= sr_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_en) begin
            for (int k = 0; k < LANES; k++) r_unit[k] <= n_unit[k];
            r_deg <= sr_deg;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_deg;
    assign o_m_axis_tdata  = OTW'({r_unit[LANE_Z], r_unit[LANE_Y], r_unit[LANE_X]});

    // A zero normal always leaves as a zero vector.
    a_deg_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |->
            r_unit[LANE_X] == '0 && r_unit[LANE_Y] == '0 && r_unit[LANE_Z] == '0)
        else $error("degenerate word carries a nonzero vector");

    // No component of a unit vector exceeds one.
    a_unit_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (r_unit[LANE_X] <= $signed(OW'(1) << FRAC_BITS))
            && (r_unit[LANE_X] >= -$signed(OW'(1) << FRAC_BITS))
            && (r_unit[LANE_Y] <= $signed(OW'(1) << FRAC_BITS))
            && (r_unit[LANE_Y] >= -$signed(OW'(1) << FRAC_BITS))
            && (r_unit[LANE_Z] <= $signed(OW'(1) << FRAC_BITS))
            && (r_unit[LANE_Z] >= -$signed(OW'(1) << FRAC_BITS)))
        else $error("normal component out of range");

    // Reset empties the pipeline.
    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

endmodule

`default_nettype wire

[dv/tb_top.sv]
`default_nettype none

module tb_top;
    import tun_pkg::*;

    localparam int CW    = COORD_WIDTH_DEF;
    localparam int FB    = FRAC_BITS_DEF;
    localparam int OW    = FB + 2;
    localparam int IN_W  = ((9*CW+7)/8)*8;
    localparam int OUT_W = ((3*OW+7)/8)*8;
    localparam int LATENCY = FB + 8;

    typedef struct packed {
        logic [OW-1:0] ux;
        logic [OW-1:0] uy;
        logic [OW-1:0] uz;
        logic          degen;
    } normal_t;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_s_axis_tvalid;
    logic             o_s_axis_tready;
    logic [IN_W-1:0]  i_s_axis_tdata;   // first_x .. third_z, lowest first
    logic             o_m_axis_tvalid;
    logic             i_m_axis_tready;
    logic [OUT_W-1:0] o_m_axis_tdata;   // unit_x, unit_y, unit_z, lowest first
    logic [0:0]       o_m_axis_tuser;   // degenerate

    triangle_unit_normal uut (.*);

    logic [IN_W-1:0] tri_queue[$];
    normal_t         normal_queue[$];
    bit              stim_done;
    int              fail_count;
    int              hold_off;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Nearest integer to |c| * 2^FB / sqrt(sum), ties away from zero:
    // largest q with (2q-1)^2 * sum <= c^2 * 2^(2FB+2).
    function automatic logic [OW-1:0] round_component(
        longint signed c, logic [127:0] sum);
        logic [127:0] lim;
        logic [127:0] lhs;
        logic [63:0]  cm;
        longint       lo;
        longint       hi;
        longint       mid;
        cm  = (c < 0) ? -c : c;
        lim = ({64'd0, cm} * {64'd0, cm}) << (2*FB + 2);
        lo  = 0;
        hi  = 1 << FB;
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            lhs = (128'(2*mid - 1) * 128'(2*mid - 1)) * sum;
            if (lhs <= lim) lo = mid;
            else hi = mid - 1;
        end
        return (c < 0) ? OW'(-lo) : OW'(lo);
    endfunction

    function automatic normal_t face_normal(logic [IN_W-1:0] word);
        longint signed p[9];
        longint signed e1[3];
        longint signed e2[3];
        longint signed n[3];
        logic [127:0]  sum;
        normal_t       r;
        for (int k = 0; k < 9; k++) p[k] = longint'($signed(word[k*CW +: CW]));
        for (int k = 0; k < 3; k++) begin
            e1[k] = p[3+k] - p[k];
            e2[k] = p[6+k] - p[3+k];
        end
        n[LANE_X] = e1[1]*e2[2] - e1[2]*e2[1];
        n[LANE_Y] = e1[2]*e2[0] - e1[0]*e2[2];
        n[LANE_Z] = e1[0]*e2[1] - e1[1]*e2[0];
        sum = '0;
        // squares reach past 64 bits, so widen before multiplying
        for (int k = 0; k < 3; k++) sum += 128'(n[k]) * 128'(n[k]);
        r = '0;
        if (sum == 0) begin
            r.degen = 1'b1;
        end else begin
            r.ux = round_component(n[LANE_X], sum);
            r.uy = round_component(n[LANE_Y], sum);
            r.uz = round_component(n[LANE_Z], sum);
        end
        return r;
    endfunction

    function automatic logic [IN_W-1:0] pack_tri(int c[9]);
        logic [IN_W-1:0] w;
        w = '0;
        for (int k = 0; k < 9; k++) w[k*CW +: CW] = CW'(c[k]);
        return w;
    endfunction

    function automatic int rand_coord(int mode);
        case (mode)
            0: return $urandom_range(0, 1) ? 32767 : -32768;
            1: return int'($urandom_range(0, 20)) - 10;
            default: return int'($signed(CW'($urandom)));
        endcase
    endfunction

    // Fill the stimulus: directed corners first, then random triangles.
    initial begin
        int c[9];
        int mode;
        int base;
        c = '{0, 0, 0, 1, 0, 0, 0, 1, 0};           tri_queue.push_back(pack_tri(c));
        c = '{0, 0, 0, 0, 0, 0, 0, 0, 0};           tri_queue.push_back(pack_tri(c));
        c = '{5, 5, 5, 5, 5, 5, 5, 5, 5};           tri_queue.push_back(pack_tri(c));
        c = '{0, 0, 0, 1, 2, 3, 2, 4, 6};           tri_queue.push_back(pack_tri(c));
        c = '{-32768, -32768, -32768, 32767, 32767, 32767, 0, 0, 0};
        tri_queue.push_back(pack_tri(c));
        c = '{-32768, -32768, 0, 32767, -32768, 0, 32767, 32767, 0};
        tri_queue.push_back(pack_tri(c));
        c = '{32767, 0, -32768, -32768, 32767, 0, 0, -32768, 32767};
        tri_queue.push_back(pack_tri(c));
        c = '{-32768, 32767, -32768, 32767, -32768, 32767, -32768, -32768, 32767};
        tri_queue.push_back(pack_tri(c));
        c = '{0, 0, 0, 0, 0, 1, 1, 0, 1};           tri_queue.push_back(pack_tri(c));
        c = '{0, 0, 0, 0, 1, 0, 0, 1, 1};           tri_queue.push_back(pack_tri(c));
        c = '{0, 0, 0, 1, 1, 0, 1, 2, 1};           tri_queue.push_back(pack_tri(c));
        c = '{0, 0, 0, 3, 0, 0, 3, 4, 0};           tri_queue.push_back(pack_tri(c));
        c = '{0, 0, 0, -1, 0, 0, -1, -1, 0};        tri_queue.push_back(pack_tri(c));
        c = '{-1, -1, -1, 32767, -32768, 1, 1, 2, -3};
        tri_queue.push_back(pack_tri(c));
        for (int i = 0; i < 650; i++) begin
            mode = $urandom_range(0, 9);
            if (mode == 9) begin
                // collinear or coincident corners
                base = $urandom_range(0, 3);
                for (int k = 0; k < 3; k++) c[k] = int'($urandom_range(0, 2000)) - 1000;
                for (int k = 0; k < 3; k++) c[3+k] = c[k] + base * (k + 1);
                for (int k = 0; k < 3; k++) c[6+k] = c[3+k] + 2 * base * (k + 1);
            end else begin
                for (int k = 0; k < 9; k++)
                    c[k] = rand_coord(mode < 2 ? 0 : (mode < 4 ? 1 : 2));
            end
            tri_queue.push_back(pack_tri(c));
        end
        stim_done = 1'b1;
    end

    // Driver: bursts of words separated by random gaps.
    int burst_left;
    int gap_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= '0;
            burst_left      <= 0;
            gap_left        <= 0;
        end else if (!i_s_axis_tvalid || o_s_axis_tready) begin
            if (i_s_axis_tvalid) normal_queue.push_back(face_normal(i_s_axis_tdata));
            if (gap_left > 0) begin
                gap_left        <= gap_left - 1;
                i_s_axis_tvalid <= 1'b0;
            end else if (tri_queue.size() > 0) begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= tri_queue.pop_front();
                if (burst_left > 0) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(0, 40);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls between always-ready windows, and one long hold-off early on.
    int rx_cycle;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            rx_cycle        <= 0;
            hold_off        <= 0;
        end else begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle == 300) hold_off <= 200;
            else if (hold_off > 0) hold_off <= hold_off - 1;
            if (rx_cycle == 300 || hold_off > 1)
                i_m_axis_tready <= 1'b0;
            else if ((rx_cycle / 128) % 3 == 0)
                i_m_axis_tready <= 1'b1;
            else
                i_m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Monitor: compare each accepted word with the oldest expected normal.
    always @(posedge i_clk) begin
        normal_t want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (normal_queue.size() == 0) begin
                $error("unexpected output word %h", o_m_axis_tdata);
                fail_count++;
            end else begin
                want = normal_queue.pop_front();
                if (o_m_axis_tdata[0 +: OW] !== want.ux) begin
                    $error("unit_x expected %0d actual %0d", $signed(want.ux),
                        $signed(o_m_axis_tdata[0 +: OW]));
                    fail_count++;
                end
                if (o_m_axis_tdata[OW +: OW] !== want.uy) begin
                    $error("unit_y expected %0d actual %0d", $signed(want.uy),
                        $signed(o_m_axis_tdata[OW +: OW]));
                    fail_count++;
                end
                if (o_m_axis_tdata[2*OW +: OW] !== want.uz) begin
                    $error("unit_z expected %0d actual %0d", $signed(want.uz),
                        $signed(o_m_axis_tdata[2*OW +: OW]));
                    fail_count++;
                end
                if (o_m_axis_tuser[0] !== want.degen) begin
                    $error("degenerate expected %0b actual %0b", want.degen,
                        o_m_axis_tuser[0]);
                    fail_count++;
                end
            end
        end
    end

    // Reset, then wait for the stimulus to drain and the pipeline to empty.
    initial begin
        i_rst_n    = 1'b0;
        fail_count = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_done);
        while (tri_queue.size() > 0 || i_s_axis_tvalid || normal_queue.size() > 0)
            @(posedge i_clk);
        repeat (4 * LATENCY) @(posedge i_clk);
        if (fail_count == 0 && normal_queue.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legitimate run.
    initial begin
        #400000;
        $display("tb_top failed");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
sv/tun_pkg.sv
sv/tun_cross.sv
sv/tun_norm.sv
sv/tun_search.sv
sv/triangle_unit_normal.sv
dv/tb_top.sv
